// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of the mosaic tile average block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define MTA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/mta_pkg.sv =====
// Shared types and constants of the mosaic tile average block.
package mta_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TILE_SIZE    = 2'd2;

    // Smallest tile edge the block works with.
    localparam int MIN_TILE = 2;

    // Reset values of the configuration registers.
    localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [6:0]  RST_TILE_SIZE    = 7'd10;

    // Queue status handed from the queue to the front part and the divider.
    typedef struct packed {
        logic space_ok;
        logic not_empty;
    } mta_q_status_t;

endpackage

// ===== src/mta_queue.sv =====
// Small queue of finished tile sums between the front part and the divider.
module mta_queue #(
    parameter int EW    = 8,
    parameter int DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  logic [EW-1:0]          push_data,
    input  logic                   pop,
    output logic [EW-1:0]          pop_data,
    output mta_pkg::mta_q_status_t status
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [EW-1:0] mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data         = mem[rd_ptr_reg];
    // Room for the entry in flight plus one more that a new beat may cause.
    assign status.space_ok  = (count_reg <= CW'(DEPTH - 2));
    assign status.not_empty = (count_reg != '0);
endmodule

// ===== src/mta_front.sv =====
// Front part: raster position tracking and per-tile-column accumulation.
module mta_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_TILE  = 64,
    parameter int TCW       = 10,
    parameter int SW        = 20,
    parameter int CW        = 13,
    parameter int EW        = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   restart,
    input  logic [11:0]            width_cfg,
    input  logic [11:0]            height_cfg,
    input  logic [6:0]             tile_cfg,
    input  logic                   in_valid,
    input  logic [31:0]            in_pixel,
    output logic                   in_ready,
    input  mta_pkg::mta_q_status_t q_status,
    output logic                   q_push,
    output logic [EW-1:0]          q_data
);
    localparam int NCOL = MAX_WIDTH / mta_pkg::MIN_TILE;
    localparam int PW   = $clog2(MAX_WIDTH + 1);
    localparam int TW   = $clog2(MAX_TILE + 1);
    localparam int OW   = $clog2(MAX_TILE);
    localparam int MW   = 4 * SW + CW;

    logic [MW-1:0]  mem [NCOL];
    logic [MW-1:0]  rd_data_reg;
    logic [MW-1:0]  fwd_data_reg;
    logic [MW-1:0]  base, wr_val;

    logic [PW-1:0]  col_pos_reg, row_pos_reg;
    logic [OW-1:0]  offx_reg, offy_reg;
    logic [TCW-1:0] tcol_reg, trow_reg;

    logic           clr_busy_reg;
    logic [TCW-1:0] clr_addr_reg;

    logic           p1_valid_reg, p1_fwd_reg, p1_done_reg, p1_fdone_reg;
    logic [31:0]    p1_pix_reg;
    logic [TCW-1:0] p1_col_reg, p1_row_reg;

    logic [PW-1:0]  w_eff, h_eff;
    logic [TW-1:0]  t_eff;
    logic           accept, row_end, last_row, x_wrap, y_wrap;
    logic [SW-1:0]  sum_a, sum_r, sum_g, sum_b;
    logic [CW-1:0]  cnt;

    always_comb begin
        if (width_cfg == '0) begin
            w_eff = PW'(1);
        end else if (32'(width_cfg) > MAX_WIDTH) begin
            w_eff = PW'(MAX_WIDTH);
        end else begin
            w_eff = PW'(width_cfg);
        end
        if (height_cfg == '0) begin
            h_eff = PW'(1);
        end else if (32'(height_cfg) > MAX_WIDTH) begin
            h_eff = PW'(MAX_WIDTH);
        end else begin
            h_eff = PW'(height_cfg);
        end
        if (32'(tile_cfg) < mta_pkg::MIN_TILE) begin
            t_eff = TW'(mta_pkg::MIN_TILE);
        end else if (32'(tile_cfg) > MAX_TILE) begin
            t_eff = TW'(MAX_TILE);
        end else begin
            t_eff = TW'(tile_cfg);
        end
    end

    assign in_ready = !clr_busy_reg && q_status.space_ok;
    assign accept   = in_valid && in_ready;
    assign row_end  = ({1'b0, col_pos_reg} + 1'b1) >= {1'b0, w_eff};
    assign last_row = ({1'b0, row_pos_reg} + 1'b1) >= {1'b0, h_eff};
    assign x_wrap   = (32'(offx_reg) + 1) >= 32'(t_eff);
    assign y_wrap   = (32'(offy_reg) + 1) >= 32'(t_eff);

    // Position bookkeeping and the clearing sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            offx_reg     <= '0;
            offy_reg     <= '0;
            tcol_reg     <= '0;
            trow_reg     <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == TCW'(NCOL - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            p1_valid_reg <= accept;
            if (accept) begin
                if (!row_end) begin
                    col_pos_reg <= col_pos_reg + 1'b1;
                    if (x_wrap) begin
                        offx_reg <= '0;
                        tcol_reg <= tcol_reg + 1'b1;
                    end else begin
                        offx_reg <= offx_reg + 1'b1;
                    end
                end else if (!last_row) begin
                    col_pos_reg <= '0;
                    offx_reg    <= '0;
                    tcol_reg    <= '0;
                    row_pos_reg <= row_pos_reg + 1'b1;
                    if (y_wrap) begin
                        offy_reg <= '0;
                        trow_reg <= trow_reg + 1'b1;
                    end else begin
                        offy_reg <= offy_reg + 1'b1;
                    end
                end else begin
                    col_pos_reg <= '0;
                    row_pos_reg <= '0;
                    offx_reg    <= '0;
                    offy_reg    <= '0;
                    tcol_reg    <= '0;
                    trow_reg    <= '0;
                end
            end
        end
    end

    // Stage one payload; the forward flag covers a write to the same column
    // that lands on the same edge as this read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_pix_reg   <= in_pixel;
            p1_col_reg   <= tcol_reg;
            p1_row_reg   <= trow_reg;
            p1_done_reg  <= (row_end || x_wrap) && (last_row || y_wrap);
            p1_fdone_reg <= row_end && last_row;
            p1_fwd_reg   <= p1_valid_reg && (p1_col_reg == tcol_reg);
            rd_data_reg  <= mem[tcol_reg];
        end
        if (p1_valid_reg) begin
            fwd_data_reg <= wr_val;
        end
    end

    always_comb begin
        base  = p1_fwd_reg ? fwd_data_reg : rd_data_reg;
        sum_a = base[4*SW+CW-1 -: SW] + SW'(p1_pix_reg[31:24]);
        sum_r = base[3*SW+CW-1 -: SW] + SW'(p1_pix_reg[23:16]);
        sum_g = base[2*SW+CW-1 -: SW] + SW'(p1_pix_reg[15:8]);
        sum_b = base[SW+CW-1 -: SW] + SW'(p1_pix_reg[7:0]);
        cnt   = base[CW-1:0] + 1'b1;
        wr_val = p1_done_reg ? '0 : {sum_a, sum_r, sum_g, sum_b, cnt};
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (p1_valid_reg) begin
            mem[p1_col_reg] <= wr_val;
        end
    end

    assign q_push = p1_valid_reg && p1_done_reg;
    assign q_data = {p1_fdone_reg, p1_row_reg, p1_col_reg, cnt, sum_a, sum_r, sum_g, sum_b};
endmodule

// ===== src/mta_div.sv =====
// Back part: bit-serial mean of four channel sums and the output register.
module mta_div #(
    parameter int TCW = 10,
    parameter int SW  = 20,
    parameter int CW  = 13,
    parameter int EW  = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mta_pkg::mta_q_status_t q_status,
    input  logic [EW-1:0]          q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [55:0]            out_data,
    output logic                   out_last
);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;
    localparam int   DW      = SW + 8;

    logic           state_reg;
    logic [2:0]     bit_reg;
    logic [DW-1:0]  rem_reg [4];
    logic [DW-1:0]  rem_next [4];
    logic [7:0]     quo_reg [4];
    logic [7:0]     quo_next [4];
    logic [DW-1:0]  trial;
    logic [CW-1:0]  cnt_reg;
    logic [TCW-1:0] col_reg, row_reg;
    logic           fdone_reg;
    logic           out_valid_reg, out_last_reg;
    logic [55:0]    out_data_reg;
    logic           out_free, step, finish;
    logic [31:0]    col_w, row_w;

    assign out_free = !out_valid_reg || out_ready;
    assign step     = (state_reg == ST_BUSY) && ((bit_reg != 3'd0) || out_free);
    assign finish   = step && (bit_reg == 3'd0);
    assign q_pop    = (state_reg == ST_IDLE) && q_status.not_empty;
    assign trial    = DW'(cnt_reg) << bit_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rem_next[i] = rem_reg[i];
            quo_next[i] = quo_reg[i];
            if (rem_reg[i] >= trial) begin
                rem_next[i] = rem_reg[i] - trial;
                quo_next[i][bit_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        state_reg <= ST_BUSY;
                    end
                end
                ST_BUSY: begin
                    if (finish) begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (!finish && out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign col_w = 32'(col_reg);
    assign row_w = 32'(row_reg);

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            bit_reg    <= 3'd7;
            fdone_reg  <= q_data[EW-1];
            row_reg    <= q_data[EW-2 -: TCW];
            col_reg    <= q_data[EW-2-TCW -: TCW];
            cnt_reg    <= q_data[4*SW+CW-1 -: CW];
            rem_reg[0] <= DW'(q_data[4*SW-1 -: SW]);
            rem_reg[1] <= DW'(q_data[3*SW-1 -: SW]);
            rem_reg[2] <= DW'(q_data[2*SW-1 -: SW]);
            rem_reg[3] <= DW'(q_data[SW-1:0]);
            for (int i = 0; i < 4; i++) begin
                quo_reg[i] <= '0;
            end
        end else if (step) begin
            bit_reg <= bit_reg - 1'b1;
            for (int i = 0; i < 4; i++) begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
        if (finish) begin
            out_data_reg <= {4'd0, quo_next[3], quo_next[2], quo_next[1], quo_next[0],
                             row_w[9:0], col_w[9:0]};
            out_last_reg <= fdone_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
endmodule

// ===== src/mosaic_tile_average_core.sv =====
// Top level of the mosaic tile average block.
// ARGB pixels stream in raster order, one beat per pixel, and the block
// emits one beat per finished square tile carrying the tile's column, row
// and truncated per-channel mean; tlast on the output marks the frame's
// last tile. A pixel is taken every clock while the queue has room and
// no clear runs. Each pixel does a pipelined read-modify-write of its tile
// column's accumulator in an on-chip memory, with a bypass so that
// neighboring pixels of one column run back to back. Finished tiles wait
// in a four-entry queue for a shared divider that takes one tile at a
// time and finds its means bit by bit, so a run of pixels that finishes
// tiles faster than the divider drains them, such as the last row of a
// band of narrow tiles, fills the queue and then holds the input off. After
// reset, and after every configuration write to a known register, the
// block clears its MAX_WIDTH/2 accumulators, one a cycle, with s_tready low;
// such a write also restarts the frame at the top-left pixel. Write the
// configuration only while the block is idle. Tile sizes below 2 act as 2,
// widths and heights of 0 act as 1.
module mosaic_tile_average_core #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_TILE  = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Pixel input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_argb[31:0]
    // Tile results.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tile_col[9:0], tile_row[19:10], avg_alpha[27:20], avg_red[35:28],
    // avg_green[43:36], avg_blue[51:44], zero fill[55:52]
    output logic [55:0] m_tdata,
    output logic        m_tlast,   // frame_done
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    localparam int NCOL = MAX_WIDTH / mta_pkg::MIN_TILE;
    localparam int TCW  = (NCOL > 1) ? $clog2(NCOL) : 1;
    localparam int SW   = 8 + $clog2(MAX_TILE * MAX_TILE);
    localparam int CW   = $clog2(MAX_TILE * MAX_TILE + 1);
    localparam int EW   = 1 + 2 * TCW + CW + 4 * SW;

    logic [11:0] width_reg, height_reg;
    logic [6:0]  tile_reg;
    logic        cfg_hit, restart;

    mta_pkg::mta_q_status_t q_status;
    logic          q_push, q_pop;
    logic [EW-1:0] q_push_data, q_pop_data;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && ((cfg_index == mta_pkg::REG_IMAGE_WIDTH)
                                  || (cfg_index == mta_pkg::REG_IMAGE_HEIGHT)
                                  || (cfg_index == mta_pkg::REG_TILE_SIZE));
    assign restart   = cfg_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mta_pkg::RST_IMAGE_WIDTH;
            height_reg <= mta_pkg::RST_IMAGE_HEIGHT;
            tile_reg   <= mta_pkg::RST_TILE_SIZE;
        end else if (cfg_valid) begin
            case (cfg_index)
                mta_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                mta_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                mta_pkg::REG_TILE_SIZE:    tile_reg   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    mta_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_TILE(MAX_TILE),
        .TCW(TCW), .SW(SW), .CW(CW), .EW(EW)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn), .restart(restart),
        .width_cfg(width_reg), .height_cfg(height_reg), .tile_cfg(tile_reg),
        .in_valid(s_tvalid), .in_pixel(s_tdata), .in_ready(s_tready),
        .q_status(q_status), .q_push(q_push), .q_data(q_push_data)
    );

    mta_queue #(.EW(EW), .DEPTH(4)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(q_push_data),
        .pop(q_pop), .pop_data(q_pop_data), .status(q_status)
    );

    mta_div #(.TCW(TCW), .SW(SW), .CW(CW), .EW(EW)) u_div (
        .aclk(aclk), .aresetn(aresetn),
        .q_status(q_status), .q_data(q_pop_data), .q_pop(q_pop),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_data(m_tdata), .out_last(m_tlast)
    );
endmodule

// ===== src/mta_checker.sv =====
// Port-level checker of the mosaic tile average block and its bind.
`include "assert_macros.svh"

module mta_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic [1:0]  cfg_index
);
    `MTA_ASSERT_RST(a_no_result_after_reset, !aresetn |=> !m_tvalid, "result after reset")
    `MTA_ASSERT_RST(a_clear_after_reset, !aresetn |=> !s_tready, "input open during clear")
    `MTA_ASSERT(a_clear_after_cfg, cfg_valid && (cfg_index == mta_pkg::REG_TILE_SIZE) |=> !s_tready, "input open after config")
    `MTA_ASSERT(a_hold_result, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
    `MTA_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[55:52] == 4'd0, "nonzero fill bits")
endmodule

bind mosaic_tile_average_core mta_checker u_mta_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index)
);

// ===== test/mosaic_tile_average_core_tb.sv =====
// Self-checking testbench of the mosaic tile average block with a built-in tile mean predictor.
module mosaic_tile_average_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Sizes used by the predictor; they match the block's defaults.
    localparam int MAX_WIDTH = 2048;
    localparam int MAX_TILE  = 64;
    localparam int NUM_COLS  = MAX_WIDTH / mta_pkg::MIN_TILE + 1;
    // Cycles to wait for the block to clear its accumulators after reset or a write, with margin.
    localparam int CLEAR_CYCLES = MAX_WIDTH / 2 + 64;

    // One finished tile as the block reports it.
    typedef struct packed {
        logic       frame_done;
        logic [7:0] avg_blue;
        logic [7:0] avg_green;
        logic [7:0] avg_red;
        logic [7:0] avg_alpha;
        logic [9:0] tile_row;
        logic [9:0] tile_col;
    } tile_mean_t;

    // One directed row: a configuration write or a pixel beat, with an optional
    // typed-in expected tile for the cases that are obvious by inspection.
    typedef struct {
        bit          is_cfg;
        logic [1:0]  index;
        logic [11:0] value;
        logic [31:0] pixel;
        bit          has_typed;
        tile_mean_t  typed;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    mosaic_tile_average_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // pixel_argb[31:0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // tile_col, tile_row, alpha, red, green, blue, zero fill
        .m_tlast   (m_tlast),   // frame_done
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the configuration and the frame walk.
    logic [11:0] pr_width;
    logic [11:0] pr_height;
    logic [6:0]  pr_tile;
    int unsigned sum_a [NUM_COLS];
    int unsigned sum_r [NUM_COLS];
    int unsigned sum_g [NUM_COLS];
    int unsigned sum_b [NUM_COLS];
    int unsigned pix_cnt [NUM_COLS];
    int unsigned col_pos, row_pos, off_x, off_y, tile_c, tile_r;

    tile_mean_t expected_tiles[$];
    int         fail_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         recv_hold;

    // Restart the frame walk, as any write to a known register does.
    task automatic restart_walk();
        for (int i = 0; i < NUM_COLS; i++) begin
            sum_a[i] = 0; sum_r[i] = 0; sum_g[i] = 0; sum_b[i] = 0; pix_cnt[i] = 0;
        end
        col_pos = 0; row_pos = 0; off_x = 0; off_y = 0; tile_c = 0; tile_r = 0;
    endtask

    task automatic predict_config(input logic [1:0] index, input logic [11:0] value);
        case (index)
            mta_pkg::REG_IMAGE_WIDTH:  pr_width  = value;
            mta_pkg::REG_IMAGE_HEIGHT: pr_height = value;
            mta_pkg::REG_TILE_SIZE:    pr_tile   = value[6:0];
            default: return;   // unknown index: nothing changes
        endcase
        restart_walk();
    endtask

    // Accumulate one pixel; returns 1 and the tile when the pixel closes a tile.
    function automatic bit accumulate_pixel(input logic [31:0] pix, output tile_mean_t tile);
        int unsigned w, h, t, col, cnt;
        bit row_end, last_row, x_end, y_end;
        w = (pr_width == 0) ? 1 : ((pr_width > MAX_WIDTH) ? MAX_WIDTH : pr_width);
        h = (pr_height == 0) ? 1 : ((pr_height > MAX_WIDTH) ? MAX_WIDTH : pr_height);
        t = (pr_tile < mta_pkg::MIN_TILE) ? mta_pkg::MIN_TILE
                                          : ((pr_tile > MAX_TILE) ? MAX_TILE : pr_tile);
        row_end  = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);
        x_end    = row_end || (off_x + 1 >= t);
        y_end    = last_row || (off_y + 1 >= t);
        col = (tile_c >= NUM_COLS) ? NUM_COLS - 1 : tile_c;
        sum_a[col] += pix[31:24];
        sum_r[col] += pix[23:16];
        sum_g[col] += pix[15:8];
        sum_b[col] += pix[7:0];
        pix_cnt[col] += 1;
        accumulate_pixel = 0;
        tile = '0;
        if (x_end && y_end) begin
            cnt = (pix_cnt[col] == 0) ? 1 : pix_cnt[col];
            tile.tile_col   = tile_c[9:0];
            tile.tile_row   = tile_r[9:0];
            tile.avg_alpha  = 8'(sum_a[col] / cnt);
            tile.avg_red    = 8'(sum_r[col] / cnt);
            tile.avg_green  = 8'(sum_g[col] / cnt);
            tile.avg_blue   = 8'(sum_b[col] / cnt);
            tile.frame_done = row_end && last_row;
            sum_a[col] = 0; sum_r[col] = 0; sum_g[col] = 0; sum_b[col] = 0; pix_cnt[col] = 0;
            accumulate_pixel = 1;
        end
        if (!row_end) begin
            col_pos++;
            if (off_x + 1 >= t) begin
                off_x = 0;
                tile_c++;
            end else begin
                off_x++;
            end
        end else if (!last_row) begin
            col_pos = 0; off_x = 0; tile_c = 0; row_pos++;
            if (off_y + 1 >= t) begin
                off_y = 0;
                tile_r++;
            end else begin
                off_y++;
            end
        end else begin
            col_pos = 0; row_pos = 0; off_x = 0; off_y = 0; tile_c = 0; tile_r = 0;
        end
    endfunction

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit on the run; far above the slowest correct run.
    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    // The receiver: random stalls per the current idle share, plus the long
    // hold-off requested by the stimulus process.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Output checker: every accepted tile beat is compared with the oldest prediction.
    always @(posedge aclk) begin
        tile_mean_t got, exp_tile;
        if (aresetn && m_tvalid && m_tready) begin
            got = tile_mean_t'({m_tlast, m_tdata[51:0]});
            if (expected_tiles.size() == 0) begin
                $error("unexpected tile beat %h", got);
                fail_count++;
            end else begin
                exp_tile = expected_tiles.pop_front();
                if (got.tile_col !== exp_tile.tile_col) begin
                    $error("tile_col exp %0d got %0d", exp_tile.tile_col, got.tile_col);
                    fail_count++;
                end
                if (got.tile_row !== exp_tile.tile_row) begin
                    $error("tile_row exp %0d got %0d", exp_tile.tile_row, got.tile_row);
                    fail_count++;
                end
                if (got.avg_alpha !== exp_tile.avg_alpha) begin
                    $error("avg_alpha exp %0d got %0d", exp_tile.avg_alpha, got.avg_alpha);
                    fail_count++;
                end
                if (got.avg_red !== exp_tile.avg_red) begin
                    $error("avg_red exp %0d got %0d", exp_tile.avg_red, got.avg_red);
                    fail_count++;
                end
                if (got.avg_green !== exp_tile.avg_green) begin
                    $error("avg_green exp %0d got %0d", exp_tile.avg_green, got.avg_green);
                    fail_count++;
                end
                if (got.avg_blue !== exp_tile.avg_blue) begin
                    $error("avg_blue exp %0d got %0d", exp_tile.avg_blue, got.avg_blue);
                    fail_count++;
                end
                if (got.frame_done !== exp_tile.frame_done) begin
                    $error("frame_done exp %0d got %0d", exp_tile.frame_done, got.frame_done);
                    fail_count++;
                end
            end
        end
    end

    // Stop offering pixels, wait until every predicted tile has been seen, then
    // let the divider and the clearing pass settle so the block is truly idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_tiles.size() != 0) @(posedge aclk);
        repeat (CLEAR_CYCLES) @(posedge aclk);
    endtask

    // One configuration beat; the predictor follows once it is accepted.
    task automatic write_config(input logic [1:0] index, input logic [11:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        predict_config(index, value);
    endtask

    // One pixel beat, with random idle cycles ahead of it. The valid stays up
    // after the accepting edge so that beats can follow back to back. The
    // prediction is queued at the accepting edge, before the tile can come out.
    task automatic send_pixel(input logic [31:0] pix, input bit has_typed = 0,
                              input tile_mean_t typed = '0);
        tile_mean_t tile;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        if (accumulate_pixel(pix, tile)) begin
            if (has_typed && tile !== typed) begin
                $error("predictor tile %h differs from typed-in tile %h", tile, typed);
                fail_count++;
            end
            expected_tiles.push_back(tile);
        end
    endtask

    // A run of random pixels; the pixels are chosen to stress the sums.
    task automatic send_frame(input int pixels);
        logic [31:0] pix;
        for (int i = 0; i < pixels; i++) begin
            case ($urandom_range(3))
                0: pix = 32'hFFFF_FFFF;
                1: pix = 32'h0000_0000;
                default: pix = $urandom;
            endcase
            send_pixel(pix);
        end
    endtask

    // Configure a frame shape, then stream a whole number of frames.
    task automatic run_shape(input logic [11:0] w, input logic [11:0] h,
                             input logic [6:0] t, input int frames);
        write_config(mta_pkg::REG_IMAGE_WIDTH, w);
        write_config(mta_pkg::REG_IMAGE_HEIGHT, h);
        write_config(mta_pkg::REG_TILE_SIZE, {5'd0, t});
        send_frame(frames * ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h));
    endtask

    // Configure a frame shape, then stream only the first pixels of a frame.
    task automatic run_partial(input logic [11:0] w, input logic [11:0] h,
                               input logic [6:0] t, input int pixels);
        write_config(mta_pkg::REG_IMAGE_WIDTH, w);
        write_config(mta_pkg::REG_IMAGE_HEIGHT, h);
        write_config(mta_pkg::REG_TILE_SIZE, {5'd0, t});
        send_frame(pixels);
    endtask

    directed_row_t directed[$];
    directed_row_t row;
    int            sent;

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        fail_count = 0;
        recv_hold  = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 48;
        pr_width  = mta_pkg::RST_IMAGE_WIDTH;
        pr_height = mta_pkg::RST_IMAGE_HEIGHT;
        pr_tile   = mta_pkg::RST_TILE_SIZE;
        restart_walk();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: a 1x1 frame, where every pixel is its own tile and
        // closes the frame, so the mean is the pixel itself.
        directed.push_back('{1, mta_pkg::REG_IMAGE_WIDTH, 12'd0, '0, 0, '0});  // zero width acts as 1
        directed.push_back('{1, mta_pkg::REG_IMAGE_HEIGHT, 12'd1, '0, 0, '0});
        directed.push_back('{0, '0, '0, 32'hFFFF_FFFF, 1, '{1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0}});
        directed.push_back('{0, '0, '0, 32'h0000_0000, 1, '{1, 0, 0, 0, 0, 0, 0}});
        directed.push_back('{0, '0, '0, 32'h1122_3344, 1, '{1, 8'h44, 8'h33, 8'h22, 8'h11, 0, 0}});
        // Unknown register index: no effect, the shape stays 1x1.
        directed.push_back('{1, 2'd3, 12'hFFF, '0, 0, '0});
        directed.push_back('{0, '0, '0, 32'hA5A5_5A5A, 1, '{1, 8'h5A, 8'h5A, 8'hA5, 8'hA5, 0, 0}});
        // A 4x3 frame with small tile sizes of 0 and 1, both acting as 2.
        directed.push_back('{1, mta_pkg::REG_IMAGE_WIDTH, 12'd4, '0, 0, '0});
        directed.push_back('{1, mta_pkg::REG_IMAGE_HEIGHT, 12'd3, '0, 0, '0});
        directed.push_back('{1, mta_pkg::REG_TILE_SIZE, 12'd0, '0, 0, '0});
        for (int i = 0; i < 6; i++) directed.push_back('{0, '0, '0, $urandom, 0, '0});
        // A config write mid-frame restarts the walk at the top-left pixel.
        directed.push_back('{1, mta_pkg::REG_TILE_SIZE, 12'd1, '0, 0, '0});
        for (int i = 0; i < 12; i++) directed.push_back('{0, '0, '0, $urandom, 0, '0});

        foreach (directed[i]) begin
            row = directed[i];
            if (row.is_cfg) write_config(row.index, row.value);
            else send_pixel(row.pixel, row.has_typed, row.typed);
        end

        // Extremes: tile above the limit acts as the limit, oversize frames clamp.
        run_shape(12'd70, 12'd2, 7'd127, 1);
        run_shape(12'd1, 12'd70, 7'd64, 1);
        run_partial(12'd4095, 12'd1, 7'd2, 64);   // width clamps to the maximum

        // Pressure: hold the receiver off for a long stretch while narrow
        // one-column tiles fill the queue and stall the input.
        write_config(mta_pkg::REG_IMAGE_WIDTH, 12'd1);
        write_config(mta_pkg::REG_IMAGE_HEIGHT, 12'd1);
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(posedge aclk);
                recv_hold = 1'b0;
            end
            send_frame(40);
        join

        // Random part, in three idle phases; mostly small frames.
        sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 9 : ((ph == 1) ? 48 : 0);
            recv_idle_pct = (ph == 0) ? 48 : ((ph == 1) ? 9 : 0);
            while (sent < 140 * (ph + 1)) begin
                logic [11:0] w, h;
                logic [6:0]  t;
                int          frames;
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
                t = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 5));
                frames = $urandom_range(1, 2);
                run_shape(w, h, t, frames);
                sent += frames * w * h;
            end
        end
        // A random-width wide row sets the width register's bits up to bit 10.
        run_partial(12'($urandom_range(1024, 2047)), 12'd1, 7'd2, 48);

        wait_idle();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/mta_pkg.sv
src/mta_queue.sv
src/mta_front.sv
src/mta_div.sv
src/mosaic_tile_average_core.sv
src/mta_checker.sv
test/mosaic_tile_average_core_tb.sv
